@@ src/capture_timestamp_extender_core_assert.svh @@
// Assertion macros for the capture timestamp extender.
// Included by capture_timestamp_extender_core, which checks its own control logic.
`ifndef CAPTURE_TIMESTAMP_EXTENDER_CORE_ASSERT_SVH
`define CAPTURE_TIMESTAMP_EXTENDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cte_pkg.sv @@
// Package for the capture timestamp extender: constants, codes and types.
// Used by capture_timestamp_extender_core; depends on nothing.
`default_nettype none

package cte_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MAX_FILL   = 16;
  localparam int FILL_CNT_W = $clog2(MAX_FILL + 1);

  localparam logic [31:0] NOMINAL_RESET = 32'd1000000;
  localparam logic [31:0] JUMP_RESET    = 32'd1000000000;
  localparam logic [63:0] FILL_MARGIN   = 64'd2000000;
  localparam logic [63:0] WINDOW        = 64'd200000;
  localparam logic [32:0] WRAP_ADJ      = 33'h0_ffff_ffff;

  // Configuration register indexes.
  localparam logic CFG_NOMINAL_PERIOD = 1'b0;
  localparam logic CFG_JUMP_TOLERANCE = 1'b1;

  // Lock codes as held in the channel memory.
  localparam logic [1:0] LK_INIT   = 2'd0;
  localparam logic [1:0] LK_UNLOCK = 2'd1;
  localparam logic [1:0] LK_LOCK   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXT,
    S_JMP,
    S_CHK,
    S_FILL,
    S_FIN
  } state_t;

  // Which epoch the widened capture is taken from.
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SAME,
    SEL_PREV,
    SEL_NEXT
  } epoch_sel_t;

  typedef struct packed {
    logic [1:0]  lock;
    logic [31:0] prev_cap_low;
    logic [63:0] prev_cap_full;
    logic [63:0] period;
  } chan_ent_t;

  localparam chan_ent_t ENT_RESET = '{
    lock:          LK_INIT,
    prev_cap_low:  32'd0,
    prev_cap_full: 64'd0,
    period:        {32'd0, NOMINAL_RESET}
  };

endpackage

`default_nettype wire

@@ src/cte_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the per-channel state of the extender.
`default_nettype none

module cte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/capture_timestamp_extender_core.sv @@
// Capture timestamp extender: a request is taken only in idle, and the next one only once the last
// has been written back. The channel state is fetched, then the lock decision, the epoch choice and
// the backwards check run in turn; when locked, up to 16 gap-fill values go out before the real capture. The rate is
// set by the single channel-state memory port and the fill loop, one value per cycle into the
// single output register while that register is free; a stall there holds the loop. Reset (rst_n low,
// synchronous) returns every channel to init through per-channel valid bits; no clearing pass.
`default_nettype none

`include "capture_timestamp_extender_core_assert.svh"

module capture_timestamp_extender_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  // Capture request channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_channel,
  input  wire logic [31:0] in_cap_low,
  input  wire logic [63:0] in_ptp_time,
  input  wire logic        in_batch_last,
  // Timestamp result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_channel,
  output logic [63:0]      out_timestamp,
  output logic             out_interpolated,
  output logic             out_last
);

  // Control state.
  cte_pkg::state_t               state_r, state_nxt;
  logic [cte_pkg::CHANNELS-1:0]  vld_r, vld_nxt;
  logic [31:0]                   nom_r, nom_nxt;
  logic [31:0]                   jump_r, jump_nxt;
  logic [31:0]                   ppl_r, ppl_nxt;
  logic [cte_pkg::FILL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Working registers of the request in flight.
  logic [1:0]                    ch_r, ch_nxt;
  logic [31:0]                   ts_r, ts_nxt;
  logic [63:0]                   ptp_r, ptp_nxt;
  logic                          blast_r, blast_nxt;
  logic [1:0]                    st_r, st_nxt;
  cte_pkg::epoch_sel_t           sel_r, sel_nxt;
  logic [63:0]                   pre_r, pre_nxt;
  logic [63:0]                   diff_r, diff_nxt;
  logic [63:0]                   dm_r, dm_nxt;
  logic [63:0]                   t_r, t_nxt;
  logic [63:0]                   cap_r, cap_nxt;

  // Output register payload.
  logic [1:0]                    out_channel_r, out_channel_nxt;
  logic [63:0]                   out_timestamp_r, out_timestamp_nxt;
  logic                          out_interpolated_r, out_interpolated_nxt;
  logic                          out_last_r, out_last_nxt;

  // Memory interface.
  logic                          ram_we, ram_re;
  logic [cte_pkg::CH_AW-1:0]     ram_raddr, ch_idx;
  cte_pkg::chan_ent_t            ram_wdata, rd_ent, ent;

  // Datapath terms.
  logic [32:0]                   ptp_l, tmp;
  logic                          cond_a, cond_b, out_free;
  logic [63:0]                   cand_same, cand_prev, cand_next, jmp_sum, jmp_dif;
  logic [63:0]                   fill_sum, fill_step, nd, win_lo, win_hi;

  assign ram_raddr = cte_pkg::CH_AW'(in_channel);
  assign ch_idx    = cte_pkg::CH_AW'(ch_r);

  cte_ram #(
    .WIDTH ($bits(cte_pkg::chan_ent_t)),
    .DEPTH (cte_pkg::CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ch_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_ent)
  );

  // An entry never written since reset reads as the reset state.
  assign ent = vld_r[ch_idx] ? rd_ent : cte_pkg::ENT_RESET;

  // The PTP low word is lifted by the wrap adjustment when it has gone round since
  // the last batch; the capture low word likewise against its previous value.
  assign ptp_l = {1'b0, ptp_r[31:0]} + ((ppl_r > ptp_r[31:0]) ? cte_pkg::WRAP_ADJ : 33'd0);
  assign tmp   = {1'b0, ts_r} + ((ent.prev_cap_low > ts_r) ? cte_pkg::WRAP_ADJ : 33'd0);
  assign cond_a = (ent.prev_cap_low <= ppl_r) && (tmp <= ptp_l);
  assign cond_b = (ent.prev_cap_low > ppl_r) && (tmp > ptp_l);

  // Epoch candidates for the widened capture and their jump-tolerance checks.
  assign cand_same = {ptp_r[63:32], ts_r};
  assign cand_prev = {ptp_r[63:32] - 32'd1, ts_r};
  assign cand_next = {ptp_r[63:32] + 32'd1, ts_r};
  assign jmp_sum   = cand_prev + {32'd0, jump_r};
  assign jmp_dif   = cand_next - {32'd0, jump_r};

  // Gap fill: dm_r already holds period plus fill margin.
  assign fill_sum  = t_r + dm_r;
  assign fill_step = t_r + diff_r;

  // Period re-estimation window; the low bound wraps for very short nominal periods.
  assign nd     = cap_r - t_r;
  assign win_lo = {32'd0, nom_r} - cte_pkg::WINDOW;
  assign win_hi = {32'd0, nom_r} + cte_pkg::WINDOW;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt            = state_r;
    vld_nxt              = vld_r;
    nom_nxt              = nom_r;
    jump_nxt             = jump_r;
    ppl_nxt              = ppl_r;
    cnt_nxt              = cnt_r;
    out_valid_nxt        = out_valid_r && !out_ready;
    ch_nxt               = ch_r;
    ts_nxt               = ts_r;
    ptp_nxt              = ptp_r;
    blast_nxt            = blast_r;
    st_nxt               = st_r;
    sel_nxt              = sel_r;
    pre_nxt              = pre_r;
    diff_nxt             = diff_r;
    dm_nxt               = dm_r;
    t_nxt                = t_r;
    cap_nxt              = cap_r;
    out_channel_nxt      = out_channel_r;
    out_timestamp_nxt    = out_timestamp_r;
    out_interpolated_nxt = out_interpolated_r;
    out_last_nxt         = out_last_r;
    ram_we               = 1'b0;
    ram_re               = 1'b0;
    ram_wdata            = '{lock: st_r, prev_cap_low: ts_r, prev_cap_full: cap_r,
                             period: diff_r};
    in_ready             = (state_r == cte_pkg::S_IDLE);

    // Configuration must only be written while no request is in flight; the block does not enforce this.
    if (cfg_we) begin
      unique case (cfg_index)
        cte_pkg::CFG_NOMINAL_PERIOD: nom_nxt  = cfg_wdata;
        cte_pkg::CFG_JUMP_TOLERANCE: jump_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      cte_pkg::S_IDLE: begin
        if (in_valid) begin
          if (int'(in_channel) < cte_pkg::CHANNELS) begin
            // Latch the request and fetch its channel state.
            ch_nxt    = in_channel;
            ts_nxt    = in_cap_low;
            ptp_nxt   = in_ptp_time;
            blast_nxt = in_batch_last;
            ram_re    = 1'b1;
            state_nxt = cte_pkg::S_EXT;
          end else if (in_batch_last) begin
            // An absent channel is ignored but still closes a batch.
            ppl_nxt = in_ptp_time[31:0];
          end
        end
      end

      cte_pkg::S_EXT: begin
        // Lock decision and choice of epoch.
        pre_nxt  = ent.prev_cap_full;
        diff_nxt = ent.period;
        sel_nxt  = cte_pkg::SEL_ZERO;
        unique case (ent.lock) inside
          cte_pkg::LK_INIT: begin
            st_nxt = cte_pkg::LK_UNLOCK;
          end
          cte_pkg::LK_UNLOCK, cte_pkg::LK_LOCK: begin
            if (cond_a) begin
              st_nxt  = cte_pkg::LK_LOCK;
              sel_nxt = (ptp_r[31:0] >= ts_r) ? cte_pkg::SEL_SAME : cte_pkg::SEL_PREV;
            end else if (cond_b) begin
              st_nxt  = cte_pkg::LK_LOCK;
              sel_nxt = (ptp_r[31:0] <= ts_r) ? cte_pkg::SEL_SAME : cte_pkg::SEL_NEXT;
            end else begin
              st_nxt = cte_pkg::LK_UNLOCK;
            end
          end
          default: begin
            st_nxt = cte_pkg::LK_INIT;
          end
        endcase
        state_nxt = cte_pkg::S_JMP;
      end

      cte_pkg::S_JMP: begin
        // A guess into a neighbouring epoch that jumps too far falls back to
        // the plain upper word.
        case (sel_r)
          cte_pkg::SEL_SAME: cap_nxt = cand_same;
          cte_pkg::SEL_PREV: cap_nxt = (jmp_sum < pre_r) ? cand_same : cand_prev;
          cte_pkg::SEL_NEXT: cap_nxt = (jmp_dif > pre_r) ? cand_same : cand_next;
          default:           cap_nxt = 64'd0;
        endcase
        state_nxt = cte_pkg::S_CHK;
      end

      cte_pkg::S_CHK: begin
        dm_nxt  = diff_r + cte_pkg::FILL_MARGIN;
        t_nxt   = pre_r;
        cnt_nxt = '0;
        // A capture that goes backwards drops the lock and the event.
        if (st_r != cte_pkg::LK_INIT && cap_r < pre_r) begin
          st_nxt    = cte_pkg::LK_UNLOCK;
          state_nxt = cte_pkg::S_FIN;
        end else if (st_r == cte_pkg::LK_LOCK && pre_r != 64'd0) begin
          state_nxt = cte_pkg::S_FILL;
        end else begin
          state_nxt = cte_pkg::S_FIN;
        end
      end

      cte_pkg::S_FILL: begin
        if (cnt_r == cte_pkg::FILL_CNT_W'(cte_pkg::MAX_FILL)) begin
          state_nxt = cte_pkg::S_FIN;
        end else if (fill_sum < cap_r) begin
          if (out_free) begin
            out_valid_nxt        = 1'b1;
            out_channel_nxt      = ch_r;
            out_timestamp_nxt    = fill_step;
            out_interpolated_nxt = 1'b1;
            out_last_nxt         = 1'b0;
            t_nxt                = fill_step;
            cnt_nxt              = cnt_r + 1'b1;
          end
        end else begin
          state_nxt = cte_pkg::S_FIN;
        end
      end

      cte_pkg::S_FIN: begin
        if (st_r == cte_pkg::LK_LOCK) begin
          if (out_free) begin
            out_valid_nxt        = 1'b1;
            out_channel_nxt      = ch_r;
            out_timestamp_nxt    = cap_r;
            out_interpolated_nxt = 1'b0;
            out_last_nxt         = 1'b1;
            if (pre_r != 64'd0 && nd > win_lo && nd < win_hi) begin
              ram_wdata.period = nd;
            end
            ram_we = 1'b1;
          end
        end else begin
          ram_wdata.period = {32'd0, nom_r};
          ram_we           = 1'b1;
        end
        if (ram_we) begin
          vld_nxt[ch_idx] = 1'b1;
          if (blast_r) begin
            ppl_nxt = ptp_r[31:0];
          end
          state_nxt = cte_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cte_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cte_pkg::S_IDLE;
      vld_r       <= '0;
      nom_r       <= cte_pkg::NOMINAL_RESET;
      jump_r      <= cte_pkg::JUMP_RESET;
      ppl_r       <= 32'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      nom_r       <= nom_nxt;
      jump_r      <= jump_nxt;
      ppl_r       <= ppl_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r               <= ch_nxt;
    ts_r               <= ts_nxt;
    ptp_r              <= ptp_nxt;
    blast_r            <= blast_nxt;
    st_r               <= st_nxt;
    sel_r              <= sel_nxt;
    pre_r              <= pre_nxt;
    diff_r             <= diff_nxt;
    dm_r               <= dm_nxt;
    t_r                <= t_nxt;
    cap_r              <= cap_nxt;
    out_channel_r      <= out_channel_nxt;
    out_timestamp_r    <= out_timestamp_nxt;
    out_interpolated_r <= out_interpolated_nxt;
    out_last_r         <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_timestamp    = out_timestamp_r;
  assign out_interpolated = out_interpolated_r;
  assign out_last         = out_last_r;

  `CTE_ASSERT_NXT(a_accept_fetches, clk, rst_n,
    in_valid && in_ready && (int'(in_channel) < cte_pkg::CHANNELS),
    state_r == cte_pkg::S_EXT, "accepted request did not start a state fetch")
  `CTE_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1,
    cnt_r <= cte_pkg::FILL_CNT_W'(cte_pkg::MAX_FILL), "gap fill count exceeded its limit")
  `CTE_ASSERT_IMP(a_out_kind, clk, rst_n, out_valid_r,
    !(out_interpolated_r && out_last_r), "interpolated timestamp marked as last")
  `CTE_ASSERT_IMP(a_fill_locked, clk, rst_n, state_r == cte_pkg::S_FILL,
    (st_r == cte_pkg::LK_LOCK) && (pre_r != 64'd0), "gap fill entered without lock")
  `CTE_ASSERT_NXT(a_write_ends, clk, rst_n, ram_we,
    state_r == cte_pkg::S_IDLE, "state write-back did not end the request")

endmodule

`default_nettype wire
